>>> design/bia_pkg.sv
// Package with the constants, payload types and control structs of the bitmap identifier allocator.
package bia_pkg;

    localparam int NUM_IDS   = 4096;
    localparam int WORD_BITS = 32;
    localparam int MAX_LIVE  = 4096;
    localparam int WORDS     = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;

    localparam int ID_W      = 12;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WORD_AW   = $clog2(WORDS);
    localparam int CNT_W     = 13;
    localparam int VIS_W     = $clog2(WORDS + 1);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] release_id;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic [1:0]      status;
    } t_out;

    typedef struct packed {
        logic load;
        logic rd;
        logic adv;
        logic wr_set;
        logic wr_clr;
        logic set_none;
        logic set_not_alloc;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic count_zero;
        logic range_bad;
        logic found;
        logic bit_set;
        logic last_visit;
    } t_stat;

endpackage

>>> design/bia_ctrl.sv
// Controller state machine that sequences the request load, word reads, checks and result hand-off.
module bia_ctrl import bia_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_idle,
    output logic  o_push
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_push  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (i_stat.mode == MODE_ALLOC && i_stat.count_zero) begin
                    o_cmd.set_none = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.mode == MODE_FREE && i_stat.range_bad) begin
                    o_cmd.set_not_alloc = 1'b1;
                    n_state             = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.mode == MODE_FREE) begin
                    if (i_stat.bit_set) begin
                        o_cmd.wr_clr = 1'b1;
                    end else begin
                        o_cmd.set_not_alloc = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (i_stat.found) begin
                    o_cmd.wr_set = 1'b1;
                    n_state      = S_DONE;
                end else if (i_stat.last_visit) begin
                    o_cmd.set_none = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

`ifndef NO_ASSERTIONS
    a_push_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> r_state == S_DONE)
        else $error("result pushed outside the done state");
    a_write_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.wr_set, o_cmd.wr_clr, o_cmd.set_none, o_cmd.set_not_alloc}))
        else $error("more than one result source selected");
    a_rd_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> r_state == S_CHECK)
        else $error("word read not followed by a check");
`endif

endmodule

>>> design/bia_dpath.sv
// Datapath with the bitmap memory, word valid bits, search registers, counters and result register.
module bia_dpath import bia_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_in_data,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_out  o_res
);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORDS-1:0]     r_wvalid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_ok;

    logic                 r_mode;
    logic [ID_W-1:0]      r_rid;
    logic [WORD_AW-1:0]   r_word;
    logic [BIT_W-1:0]     r_off;
    logic                 r_first;
    logic [VIS_W-1:0]     r_visits;
    logic [ID_W-1:0]      r_last;
    logic [CNT_W-1:0]     r_free_count;
    t_out                 r_res;

    logic [ID_W-1:0]      start_pos;
    logic [WORD_BITS-1:0] eff_word;
    logic [WORD_BITS-1:0] masked;
    logic [BIT_W-1:0]     hit;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;

    assign start_pos = (32'(r_last) == NUM_IDS - 1) ? '0 : r_last + 1'b1;
    assign eff_word  = r_rd_ok ? r_rd_data : '0;
    assign masked    = ~eff_word & (r_first ? ({WORD_BITS{1'b1}} << r_off)
                                            : {WORD_BITS{1'b1}});

    always_comb begin
        hit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                hit = BIT_W'(i);
            end
        end
    end

    assign we    = i_cmd.wr_set | i_cmd.wr_clr;
    assign wdata = i_cmd.wr_set ? (eff_word | (WORD_BITS'(1) << hit))
                                : (eff_word & ~(WORD_BITS'(1) << r_rid[BIT_W-1:0]));

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_word] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_word];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid     <= '0;
            r_rd_ok      <= 1'b0;
            r_last       <= ID_W'(NUM_IDS - 1);
            r_free_count <= CNT_W'(MAX_LIVE);
        end else begin
            if (we) begin
                r_wvalid[r_word] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rd_ok <= r_wvalid[r_word];
            end
            if (i_cmd.wr_set) begin
                r_last       <= {r_word, hit};
                r_free_count <= r_free_count - 1'b1;
            end else if (i_cmd.wr_clr) begin
                r_free_count <= r_free_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_in_data.mode;
            r_rid    <= i_in_data.release_id;
            r_first  <= 1'b1;
            r_visits <= '0;
            r_off    <= start_pos[BIT_W-1:0];
            if (i_in_data.mode == MODE_FREE) begin
                r_word <= i_in_data.release_id[ID_W-1:BIT_W];
            end else begin
                r_word <= start_pos[ID_W-1:BIT_W];
            end
        end else if (i_cmd.adv) begin
            r_first  <= 1'b0;
            r_visits <= r_visits + 1'b1;
            r_word   <= (32'(r_word) == WORDS - 1) ? '0 : r_word + 1'b1;
        end
        if (i_cmd.wr_set) begin
            r_res <= '{granted_id: {r_word, hit}, status: ST_OK};
        end else if (i_cmd.wr_clr) begin
            r_res <= '{granted_id: r_rid, status: ST_OK};
        end else if (i_cmd.set_none) begin
            r_res <= '{granted_id: '0, status: ST_NONE};
        end else if (i_cmd.set_not_alloc) begin
            r_res <= '{granted_id: r_rid, status: ST_NOT_ALLOC};
        end
    end

    assign o_stat.mode       = r_mode;
    assign o_stat.count_zero = (r_free_count == '0);
    assign o_stat.range_bad  = (32'(r_rid) >= NUM_IDS);
    assign o_stat.found      = |masked;
    assign o_stat.bit_set    = eff_word[r_rid[BIT_W-1:0]];
    assign o_stat.last_visit = (32'(r_visits) == WORDS);
    assign o_res             = r_res;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= CNT_W'(MAX_LIVE))
        else $error("free count above its limit");
    a_set_needs_clear_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_set |-> (|masked) && r_free_count != '0)
        else $error("identifier granted without a clear bit or free count");
    a_set_lowers_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_set |=> r_free_count == $past(r_free_count) - 1'b1)
        else $error("grant did not lower the free count");
    a_clr_needs_set_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_clr |-> eff_word[r_rid[BIT_W-1:0]])
        else $error("free of an identifier that was not allocated");
`endif

endmodule

>>> design/bitmap_id_allocator.sv
// Top level of the bitmap identifier allocator: controller, datapath and output register.
// One transaction at a time is taken. A free passes the read and check states once: its
// bitmap word is read and its bit checked before the result is set. An allocate passes both
// states for each bitmap word visited, from the identifier after the last grant, until a word
// with a clear bit is found or the search wraps through the whole bitmap; the single-port
// bitmap memory with its registered read needs both states per word. An allocate with a free
// count of zero gets its result without a read. Only once the result is pushed is the next
// transaction accepted, while the finished result waits in the output register.
// The bitmap is clear right after reset; no clearing pass is needed.
module bitmap_id_allocator import bia_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd cmd;
    t_stat stat;
    t_out res;
    logic idle;
    logic push;
    logic out_free;
    logic r_out_valid;
    t_out r_out_data;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !idle;

    bia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle),
        .o_push     (push)
    );

    bia_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> test/tb_top.sv
// Testbench for the bitmap identifier allocator: directed table, random traffic and full-pool runs.
`timescale 1ns / 100ps

module tb_top;
    import bia_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        t_in  req;
        logic typed;
        t_out want;
    } t_dir_row;

    localparam int DIR_ROWS = 15;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{'{MODE_ALLOC, 12'h000}, 1'b1, '{12'd0, ST_OK}},
        '{'{MODE_ALLOC, 12'hFFF}, 1'b1, '{12'd1, ST_OK}},
        '{'{MODE_FREE,  12'h000}, 1'b1, '{12'd0, ST_OK}},
        '{'{MODE_FREE,  12'h000}, 1'b1, '{12'd0, ST_NOT_ALLOC}},
        '{'{MODE_FREE,  12'hFFF}, 1'b1, '{12'hFFF, ST_NOT_ALLOC}},
        '{'{MODE_FREE,  12'hAAA}, 1'b1, '{12'hAAA, ST_NOT_ALLOC}},
        '{'{MODE_FREE,  12'h555}, 1'b1, '{12'h555, ST_NOT_ALLOC}},
        '{'{MODE_ALLOC, 12'h555}, 1'b1, '{12'd2, ST_OK}},
        '{'{MODE_ALLOC, 12'hAAA}, 1'b1, '{12'd3, ST_OK}},
        '{'{MODE_FREE,  12'h001}, 1'b1, '{12'd1, ST_OK}},
        '{'{MODE_FREE,  12'h003}, 1'b1, '{12'd3, ST_OK}},
        '{'{MODE_ALLOC, 12'h000}, 1'b0, '0},
        '{'{MODE_FREE,  12'h002}, 1'b0, '0},
        '{'{MODE_FREE,  12'h004}, 1'b0, '0},
        '{'{MODE_ALLOC, 12'h000}, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    bit [NUM_IDS-1:0] pool_map;
    logic [ID_W-1:0]  pool_last;
    int               pool_free;

    t_out pending_grants [$];
    int   mismatches = 0;
    int   cycle_count = 0;
    int   send_calm = 0;
    int   recv_calm = 0;

    bitmap_id_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, pending_grants.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int draw_idle(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic t_out predict_grant(input t_in req);
        t_out res;
        int   pos;
        int   n;
        bit   found;
        res.granted_id = '0;
        res.status = ST_OK;
        if (req.mode == MODE_ALLOC) begin
            if (pool_free == 0) begin
                res.status = ST_NONE;
            end else begin
                pos = (int'(pool_last) + 1) % NUM_IDS;
                found = 1'b0;
                n = 0;
                while (n < NUM_IDS && !found) begin
                    if (!pool_map[pos]) begin
                        found = 1'b1;
                    end else begin
                        pos = (pos + 1) % NUM_IDS;
                    end
                    n++;
                end
                if (found) begin
                    pool_map[pos] = 1'b1;
                    pool_last = ID_W'(pos);
                    pool_free--;
                    res.granted_id = ID_W'(pos);
                end else begin
                    res.status = ST_NONE;
                end
            end
        end else begin
            res.granted_id = req.release_id;
            if (int'(req.release_id) >= NUM_IDS || !pool_map[req.release_id]) begin
                res.status = ST_NOT_ALLOC;
            end else begin
                pool_map[req.release_id] = 1'b0;
                pool_free++;
            end
        end
        return res;
    endfunction

    function automatic logic [ID_W-1:0] pick_live_id();
        int pos;
        pos = $urandom_range(0, NUM_IDS - 1);
        while (!pool_map[pos]) begin
            pos = (pos + 1) % NUM_IDS;
        end
        return ID_W'(pos);
    endfunction

    task automatic offer_request(input t_in req, input logic typed, input t_out want);
        int   gap;
        t_out got;
        gap = draw_idle(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = predict_grant(req);
        pending_grants.push_back(typed ? want : got);
    endtask

    task automatic await_drain();
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_in req;
        int  roll;
        int  k;
        int  waited;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        pool_map = '0;
        pool_last = ID_W'(NUM_IDS - 1);
        pool_free = MAX_LIVE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            offer_request(DIR_TABLE[r].req, DIR_TABLE[r].typed, DIR_TABLE[r].want);
        end
        await_drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            roll = $urandom_range(0, 99);
            req.release_id = ID_W'($urandom_range(0, NUM_IDS - 1));
            if (roll < 50) begin
                req.mode = MODE_ALLOC;
            end else if (roll < 85 && pool_free < MAX_LIVE) begin
                req.mode = MODE_FREE;
                req.release_id = pick_live_id();
            end else begin
                req.mode = MODE_FREE;
            end
            offer_request(req, 1'b0, '0);
        end
        await_drain();

        // Fill the pool completely; the search wraps past the top on the way.
        req.mode = MODE_ALLOC;
        while (pool_free > 0) begin
            req.release_id = ID_W'($urandom_range(0, NUM_IDS - 1));
            offer_request(req, 1'b0, '0);
        end

        // With the pool full, free a few identifiers and take them back plus one more.
        for (int round = 0; round < 4; round++) begin
            req.mode = MODE_ALLOC;
            offer_request(req, 1'b0, '0);
            k = $urandom_range(1, 3);
            for (int j = 0; j < k; j++) begin
                req.mode = MODE_FREE;
                req.release_id = pick_live_id();
                offer_request(req, 1'b0, '0);
            end
            req.mode = MODE_ALLOC;
            for (int j = 0; j <= k; j++) begin
                req.release_id = ID_W'($urandom_range(0, NUM_IDS - 1));
                offer_request(req, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_grants.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_grants.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_grants.size());
            mismatches += pending_grants.size();
        end
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        t_out want;
        int   gap;
        int   taken;
        i_out_stall <= 1'b0;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // One long hold-off lets the block fill up and stall its input.
            gap = (taken == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_idle(recv_calm);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result: granted_id %0d status %0d", $time,
                         o_out_data.granted_id, o_out_data.status);
                mismatches++;
            end else begin
                want = pending_grants.pop_front();
                if (o_out_data.granted_id !== want.granted_id) begin
                    $display("%0t: granted_id expected %0d actual %0d", $time,
                             want.granted_id, o_out_data.granted_id);
                    mismatches++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_out_data.status);
                    mismatches++;
                end
            end
        end
    end

endmodule
